/* rtl/bem_pkg.sv */
// Package for the button event remapper.
// Holds table size, stream widths and controller/datapath handshake types.
// No dependencies.
`default_nettype none
package bem_pkg;

  localparam int NUM_BUTTONS = 32;
  localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  localparam int IN_DATA_W   = 264;
  localparam int OUT_DATA_W  = 264;

  localparam logic [1:0] KIND_KEY = 2'd0;
  localparam logic [1:0] KIND_PTR = 2'd1;

  localparam logic ACTION_REPORT = 1'b0;
  localparam logic ACTION_MAP    = 1'b1;

  localparam logic RESULT_KEY = 1'b0;
  localparam logic RESULT_PTR = 1'b1;

  typedef struct packed {
    logic write_entry;
    logic load_report;
    logic step;
    logic emit_ptr;
  } bem_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic key_change;
    logic walk_done;
  } bem_status_t;

endpackage
`default_nettype wire

/* rtl/bem_ctrl.sv */
// Controller of the button event remapper: idle, button walk, pointer result.
// Depends on bem_pkg; drives commands into bem_datapath.
`default_nettype none
module bem_ctrl
  import bem_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_action,
  output logic             in_ready,
  input  wire bem_status_t status,
  output bem_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_PTR  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next       = state;
    cmd              = '0;
    cmd.write_entry  = accept && (in_action == ACTION_MAP);
    cmd.load_report  = accept && (in_action == ACTION_REPORT);
    unique case (state)
      ST_IDLE: begin
        if (cmd.load_report) state_next = ST_WALK;
      end
      ST_WALK: begin
        cmd.step = !(status.key_change && status.out_busy);
        if (cmd.step && status.walk_done) state_next = ST_PTR;
      end
      ST_PTR: begin
        cmd.emit_ptr = !status.out_busy;
        if (cmd.emit_ptr) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/bem_datapath.sv */
// Datapath of the button event remapper: map table, report registers,
// walk index, resultant mask accumulator and output register. Uses bem_pkg.
`default_nettype none
module bem_datapath
  import bem_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bem_cmd_t              cmd,
  output bem_status_t                status,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_DATA_W-1:0]      out_data,
  output logic                       out_kind,
  output logic                       out_last
);

  logic [1:0]  map_kind  [NUM_BUTTONS];
  logic [15:0] map_page  [NUM_BUTTONS];
  logic [15:0] map_usage [NUM_BUTTONS];
  logic [31:0] map_mask  [NUM_BUTTONS];

  logic [31:0] prev_raw;
  logic [31:0] prev_result;
  logic [31:0] raw;
  logic [31:0] delta;
  logic [31:0] acc;
  logic [31:0] move_x;
  logic [31:0] move_y;
  logic [31:0] move_z;
  logic [63:0] stamp;
  logic [IDX_W-1:0] idx;

  logic [4:0]  entry_index;
  logic [1:0]  entry_kind;
  logic        entry_ok;
  logic [IDX_W-1:0] widx;
  logic        changed;
  logic        down;
  logic        key_emit;

  assign entry_index = in_data[196:192];
  assign entry_kind  = in_data[198:197];
  assign entry_ok    = ({1'b0, entry_index} < 6'(NUM_BUTTONS));
  assign widx        = entry_index[IDX_W-1:0];

  assign changed  = delta[idx];
  assign down     = raw[idx];
  assign key_emit = changed && (map_kind[idx] == KIND_KEY);

  assign status.out_busy   = out_valid && !out_ready;
  assign status.key_change = key_emit;
  assign status.walk_done  = (idx == IDX_W'(NUM_BUTTONS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        map_kind[i]  <= KIND_PTR;
        map_page[i]  <= '0;
        map_usage[i] <= '0;
        map_mask[i]  <= 32'(1) << i;
      end
    end else if (cmd.write_entry && entry_ok) begin
      map_kind[widx] <= entry_kind;
      if (entry_kind == KIND_KEY) begin
        map_page[widx]  <= in_data[214:199];
        map_usage[widx] <= in_data[230:215];
      end else if (entry_kind == KIND_PTR) begin
        map_mask[widx] <= in_data[262:231];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw    <= '0;
      prev_result <= '0;
    end else begin
      if (cmd.load_report) prev_raw <= in_data[31:0];
      if (cmd.emit_ptr) prev_result <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_report) begin
      raw    <= in_data[31:0];
      delta  <= in_data[31:0] ^ prev_raw;
      move_x <= in_data[63:32];
      move_y <= in_data[95:64];
      move_z <= in_data[127:96];
      stamp  <= in_data[191:128];
      acc    <= prev_result;
      idx    <= '0;
    end else if (cmd.step) begin
      if (changed && (map_kind[idx] == KIND_PTR)) begin
        acc <= down ? (acc | map_mask[idx]) : (acc & ~map_mask[idx]);
      end
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.step && key_emit) || cmd.emit_ptr) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && key_emit) begin
      out_kind <= RESULT_KEY;
      out_last <= 1'b0;
      out_data <= {7'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, down,
                   map_usage[idx], map_page[idx], stamp};
    end else if (cmd.emit_ptr) begin
      out_kind <= RESULT_PTR;
      out_last <= 1'b1;
      out_data <= {7'd0, prev_result, acc, move_z, move_y, move_x, 1'b0,
                   16'd0, 16'd0, stamp};
    end
  end

endmodule
`default_nettype wire

/* rtl/button_event_remapper.sv */
// Button event remapper top level: remaps pointer buttons through a table.
// A map write is accepted in the idle state and updates the table. A report walks
// NUM_BUTTONS buttons, one per cycle while no key result is held by a busy output,
// registering each key result as its button is reached, and then the pointer result.
// The next item is not accepted until the pointer result is registered for output.
// Reset: synchronous; table returns to identity pointer masks, masks clear.
`default_nettype none
module button_event_remapper
  import bem_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // raw_buttons, move_x, move_y, move_z, stamp, entry_index, entry_kind,
  // entry_page, entry_usage, entry_mask, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_stamp, key_page, key_usage, key_down, out_x, out_y, out_z,
  // new_buttons, old_buttons, zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // result_kind
  output logic                       m_axis_tuser,
  output logic                       m_axis_tlast
);

  bem_cmd_t    cmd;
  bem_status_t status;

  bem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bem_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for button_event_remapper: map writes and pointer reports
// go in over the input stream, and a scoreboard predicts the key and pointer results.
// Depends on bem_pkg and the button_event_remapper RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bem_pkg::*;

  localparam logic [1:0] KIND_IGNORE = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 3 * (NUM_BUTTONS + 2);
  localparam int RANDOM_ITEMS = 70;

  // raw, x, y, z, stamp, index, kind, page, usage, mask, pad (lowest bit up)
  typedef struct packed {
    logic        pad;
    logic [31:0] mask;
    logic [15:0] usage;
    logic [15:0] page;
    logic [1:0]  kind;
    logic [4:0]  index;
    logic [63:0] stamp;
    logic [31:0] z, y, x;
    logic [31:0] raw;
  } item_word_t;

  // stamp, page, usage, down, x, y, z, new, old, pad (lowest bit up)
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] old_mask, new_mask;
    logic [31:0] z, y, x;
    logic        down;
    logic [15:0] usage, page;
    logic [63:0] stamp;
  } event_word_t;

  typedef struct {
    logic        kind;
    logic        last;
    event_word_t word;
  } remap_event_t;

  class remap_scoreboard;
    logic [1:0]  kind_tbl[NUM_BUTTONS];
    logic [15:0] page_tbl[NUM_BUTTONS];
    logic [15:0] usage_tbl[NUM_BUTTONS];
    logic [31:0] mask_tbl[NUM_BUTTONS];
    logic [31:0] last_raw;
    logic [31:0] last_mask;
    remap_event_t pending[$];
    int errors, reports, map_writes, key_events, ptr_events;

    function new();
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        kind_tbl[i]  = KIND_PTR;
        page_tbl[i]  = '0;
        usage_tbl[i] = '0;
        mask_tbl[i]  = 32'd1 << i;
      end
      last_raw = '0;
      last_mask = '0;
    endfunction

    function void note_input(logic action, item_word_t it);
      logic [31:0] changed;
      logic [31:0] mask_now;
      remap_event_t ev;
      if (action == ACTION_MAP) begin
        map_writes++;
        if (int'(it.index) < NUM_BUTTONS) begin
          kind_tbl[it.index] = it.kind;
          if (it.kind == KIND_KEY) begin
            page_tbl[it.index]  = it.page;
            usage_tbl[it.index] = it.usage;
          end else if (it.kind == KIND_PTR) begin
            mask_tbl[it.index] = it.mask;
          end
        end
        return;
      end
      reports++;
      changed = it.raw ^ last_raw;
      mask_now = last_mask;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (changed[i]) begin
          if (kind_tbl[i] == KIND_KEY) begin
            ev.kind = RESULT_KEY;
            ev.last = 1'b0;
            ev.word = '0;
            ev.word.stamp = it.stamp;
            ev.word.page = page_tbl[i];
            ev.word.usage = usage_tbl[i];
            ev.word.down = it.raw[i];
            pending.push_back(ev);
          end else if (kind_tbl[i] == KIND_PTR) begin
            mask_now = it.raw[i] ? (mask_now | mask_tbl[i]) : (mask_now & ~mask_tbl[i]);
          end
        end
      end
      last_raw = it.raw;
      ev.kind = RESULT_PTR;
      ev.last = 1'b1;
      ev.word = '0;
      ev.word.stamp = it.stamp;
      ev.word.x = it.x;
      ev.word.y = it.y;
      ev.word.z = it.z;
      ev.word.new_mask = mask_now;
      ev.word.old_mask = last_mask;
      pending.push_back(ev);
      last_mask = mask_now;
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic kind, logic last, event_word_t w);
      remap_event_t ev;
      if (pending.size() == 0) begin
        $error("unexpected result: kind %0d, last %0d", kind, last);
        errors++;
        return;
      end
      ev = pending.pop_front();
      if (kind == RESULT_KEY) key_events++;
      else ptr_events++;
      check_field("result_kind", ev.kind, kind);
      check_field("last", ev.last, last);
      check_field("out_stamp", ev.word.stamp, w.stamp);
      check_field("key_page", ev.word.page, w.page);
      check_field("key_usage", ev.word.usage, w.usage);
      check_field("key_down", ev.word.down, w.down);
      check_field("out_x", ev.word.x, w.x);
      check_field("out_y", ev.word.y, w.y);
      check_field("out_z", ev.word.z, w.z);
      check_field("new_buttons", ev.word.new_mask, w.new_mask);
      check_field("old_buttons", ev.word.old_mask, w.old_mask);
      check_field("pad", ev.word.pad, w.pad);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  remap_scoreboard sb = new();
  bit steady;
  bit sender_burst;
  bit hold_req;
  int cycle_count;
  int input_stalls;
  logic [31:0] cur_raw;

  button_event_remapper uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (s_axis_tvalid && !s_axis_tready) input_stalls++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_motion();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_stamp();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic item_word_t filler();
    item_word_t it;
    it = item_word_t'(264'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom}));
    it.pad = 1'b0;
    return it;
  endfunction

  // called at a rising edge; returns at a rising edge
  task automatic send_item(input logic action, input item_word_t it);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= action;
    s_axis_tdata <= it;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(action, it);
    gap = (steady || sender_burst) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_report(input logic [31:0] raw, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z,
                             input logic [63:0] stamp);
    item_word_t it;
    it = filler();
    it.raw = raw;
    it.x = x;
    it.y = y;
    it.z = z;
    it.stamp = stamp;
    cur_raw = raw;
    send_item(ACTION_REPORT, it);
  endtask

  task automatic send_map(input logic [4:0] index, input logic [1:0] kind,
                          input logic [15:0] page, input logic [15:0] usage,
                          input logic [31:0] mask);
    item_word_t it;
    it = filler();
    it.index = index;
    it.kind = kind;
    it.page = page;
    it.usage = usage;
    it.mask = mask;
    send_item(ACTION_MAP, it);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic send_random_report();
    logic [31:0] raw;
    case ($urandom_range(0, 9))
      0: raw = '0;
      1: raw = '1;
      2, 3, 4: raw = cur_raw ^ (32'd1 << $urandom_range(0, 31));
      5, 6, 7: raw = cur_raw ^ ($urandom & $urandom & $urandom);
      8: raw = cur_raw;
      default: raw = $urandom;
    endcase
    send_report(raw, pick_motion(), pick_motion(), pick_motion(), pick_stamp());
  endtask

  task automatic send_random_map();
    logic [1:0]  kind;
    logic [31:0] mask;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) kind = KIND_KEY;
    else if (r < 80) kind = KIND_PTR;
    else if (r < 90) kind = KIND_IGNORE;
    else kind = KIND_SPARE;
    mask = $urandom_range(0, 1) ? $urandom : (32'd1 << $urandom_range(0, 31));
    send_map(5'($urandom_range(0, 31)), kind, 16'($urandom), 16'($urandom), mask);
  endtask

  // result side: check each transaction, then choose tready for the next cycle
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tlast, event_word_t'(m_axis_tdata));
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser <= ACTION_REPORT;
    s_axis_tdata <= '0;
    cur_raw = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity table: press and release everything, motion and stamp extremes
    send_report('1, 32'h7fff_ffff, 32'h8000_0000, 32'h0, '1);
    send_report('0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, '0);
    send_report(32'h8000_0001, 32'h1, 32'h0, 32'h8000_0000, 64'h8000_0000_0000_0001);
    send_report(32'h8000_0001, 32'h0, 32'h0, 32'h0, 64'h1);
    send_map(5'd0, KIND_KEY, 16'hffff, 16'hffff, 32'h0);
    send_map(5'd31, KIND_KEY, 16'h0000, 16'h0001, '1);
    send_map(5'd1, KIND_PTR, 16'h1234, 16'h5678, '1);
    send_map(5'd2, KIND_IGNORE, 16'hffff, 16'hffff, '1);
    send_map(5'd3, KIND_SPARE, 16'hffff, 16'hffff, '1);
    send_map(5'd4, KIND_PTR, 16'hffff, 16'hffff, 32'h0);
    send_map(5'd5, KIND_KEY, 16'h0007, 16'h00e0, 32'h0);
    send_map(5'd5, KIND_PTR, 16'haaaa, 16'haaaa, 32'h8000_0000);
    send_report('1, 32'h5, 32'h6, 32'h7, 64'h0123_4567_89ab_cdef);
    send_report(32'h0000_0002, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1);
    send_report('0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    send_report(32'h8000_001f, 32'h0, 32'h0, 32'h0, 64'h2);
    send_report(32'h0000_000c, 32'h0, 32'h0, 32'h0, 64'h3);
    send_map(5'd31, KIND_PTR, 16'h0, 16'h0, 32'hffff_0000);
    send_map(5'd0, KIND_PTR, 16'h0, 16'h0, 32'h0000_ffff);
    send_report('1, 32'h1, 32'h1, 32'h1, 64'h4);
    send_report(32'h7fff_fffe, 32'h2, 32'h2, 32'h2, 64'h5);

    // hold off the receiver while reports keep coming, then drain
    hold_req = 1'b1;
    sender_burst = 1'b1;
    repeat (12) send_random_report();
    sender_burst = 1'b0;
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 20) steady = 1'b1;
      if (n == 35) steady = 1'b0;
      if (n == 50) wait_drained();
      if ($urandom_range(0, 99) < 30) send_random_map();
      else send_random_report();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d reports and %0d map writes;", sb.reports, sb.map_writes);
    $display("checked %0d key and %0d pointer results, input held back %0d cycles.",
             sb.key_events, sb.ptr_events, input_stalls);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
